// ----- rtl/arc_pkg.sv -----
// shared constants, codes and types of the alphabet radix codec
`default_nettype none

package arc_pkg;

   localparam int MAX_SYMBOLS  = 16;
   localparam int SYMBOL_BYTES = 4;
   localparam int MAX_DIGITS   = 31;

   localparam int OP_W    = 2;
   localparam int SLOT_W  = 4;
   localparam int SYM_W   = 8 * SYMBOL_BYTES;
   localparam int VAL_W   = 31;
   localparam int KIND_W  = 3;
   localparam int RDX_W   = 5;
   localparam int TBL_AW  = $clog2(MAX_SYMBOLS);
   localparam int DIG_AW  = $clog2(MAX_DIGITS);
   localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
   localparam int WORK_W  = 32;
   localparam int DIV_BITS   = 8;
   localparam int DIV_ROUNDS = WORK_W / DIV_BITS;
   localparam int RND_W   = $clog2(DIV_ROUNDS);
   localparam int PROD_W  = VAL_W + RDX_W + 1;
   localparam int RADIX_MIN = 2;
   localparam int CSR_RESET = 2;

   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
   localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

   localparam logic [KIND_W-1:0] KIND_SYMBOL   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_VALUE    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INVALID  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SLOT_W-1:0] slot;
      logic [SYM_W-1:0]  symbol;
      logic [VAL_W-1:0]  value;
      logic              end_of_string;
   } arc_req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SYM_W-1:0]  digit_symbol;
      logic [VAL_W-1:0]  decoded;
      logic              last;
   } arc_rsp_type;

   typedef struct packed {
      logic accept;
      logic load_tbl;
      logic div_step;
      logic dig_rd;
      logic tbl_rd;
      logic tbl_sel_dig;
      logic emit_sym;
      logic emit_zero;
      logic srch_cmp;
      logic emit_dec;
   } arc_cmd_type;

   typedef struct packed {
      logic req_zero;
      logic div_last;
      logic quo_zero;
      logic dig_full;
      logic cnt_one;
      logic match;
      logic srch_end;
      logic eos;
      logic out_free;
   } arc_sts_type;

endpackage

`default_nettype wire

// ----- rtl/arc_if.sv -----
// valid/ready channel interfaces for request and response transactions
`default_nettype none

interface arc_req_if;
   import arc_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [SLOT_W-1:0] slot;
   logic [SYM_W-1:0]  symbol;
   logic [VAL_W-1:0]  value;
   logic              end_of_string;

   modport source (output valid, output op, output slot, output symbol, output value,
                   output end_of_string, input ready);
   modport sink   (input valid, input op, input slot, input symbol, input value,
                   input end_of_string, output ready);
endinterface

interface arc_rsp_if;
   import arc_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [SYM_W-1:0]  digit_symbol;
   logic [VAL_W-1:0]  decoded;
   logic              last;

   modport source (output valid, output kind, output digit_symbol, output decoded,
                   output last, input ready);
   modport sink   (input valid, input kind, input digit_symbol, input decoded,
                   input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/arc_ctrl.sv -----
// control state machine sequencing load, encode and decode transactions
`default_nettype none

module arc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [arc_pkg::OP_W-1:0] req_op,
   output logic                        req_ready,
   output arc_pkg::arc_cmd_type        cmd,
   input  arc_pkg::arc_sts_type        sts
);
   import arc_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_ZERO     = 4'd1;
   localparam logic [3:0] ST_DIV      = 4'd2;
   localparam logic [3:0] ST_RD_DIG   = 4'd3;
   localparam logic [3:0] ST_RD_TBL   = 4'd4;
   localparam logic [3:0] ST_EMIT     = 4'd5;
   localparam logic [3:0] ST_SRCH_RD  = 4'd6;
   localparam logic [3:0] ST_SRCH_CMP = 4'd7;
   localparam logic [3:0] ST_DEC_FIN  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_op)
                  OP_LOAD: begin
                     cmd.load_tbl = 1'b1;
                  end
                  OP_ENCODE: begin
                     state_in = sts.req_zero ? ST_ZERO : ST_DIV;
                  end
                  OP_DECODE: begin
                     state_in = ST_SRCH_RD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ZERO: begin
            if (sts.out_free) begin
               cmd.emit_zero = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last && (sts.quo_zero || sts.dig_full)) begin
               state_in = ST_RD_DIG;
            end
         end
         ST_RD_DIG: begin
            cmd.dig_rd = 1'b1;
            state_in   = ST_RD_TBL;
         end
         ST_RD_TBL: begin
            cmd.tbl_rd      = 1'b1;
            cmd.tbl_sel_dig = 1'b1;
            state_in        = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_sym = 1'b1;
               state_in     = sts.cnt_one ? ST_IDLE : ST_RD_DIG;
            end
         end
         ST_SRCH_RD: begin
            cmd.tbl_rd = 1'b1;
            state_in   = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            cmd.srch_cmp = 1'b1;
            state_in     = (sts.match || sts.srch_end) ? ST_DEC_FIN : ST_SRCH_RD;
         end
         ST_DEC_FIN: begin
            if (!sts.eos) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.emit_dec = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/arc_dp.sv -----
// datapath: symbol table, digit buffer, radix divider, accumulator, output register
`default_nettype none

module arc_dp (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [arc_pkg::RDX_W-1:0] csr_write_data,
   input  arc_pkg::arc_req_type           req,
   input  arc_pkg::arc_cmd_type           cmd,
   output arc_pkg::arc_sts_type           sts,
   output logic                           rsp_valid,
   output arc_pkg::arc_rsp_type           rsp,
   input  wire logic                      rsp_ready
);
   import arc_pkg::*;

   logic [SYM_W-1:0]  table_mem [MAX_SYMBOLS];
   logic [TBL_AW-1:0] dig_mem   [MAX_DIGITS];

   logic [RDX_W-1:0]  csr_ff;
   logic [RDX_W-1:0]  radix;
   logic [WORK_W-1:0] work_ff;
   logic [RDX_W-1:0]  rem_ff;
   logic [RND_W-1:0]  round_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [TBL_AW-1:0] srch_ff;
   logic [SYM_W-1:0]  sym_ff;
   logic              eos_ff;
   logic [VAL_W-1:0]  acc_ff;
   logic              invalid_ff;
   logic              overflow_ff;
   logic [TBL_AW-1:0] dig_rd_ff;
   logic [SYM_W-1:0]  tbl_rd_ff;
   logic              rsp_valid_ff;
   arc_rsp_type       rsp_ff;
   arc_rsp_type       rsp_in;

   logic [WORK_W-1:0] div_work_in;
   logic [RDX_W-1:0]  div_rem_in;
   logic [TBL_AW-1:0] tbl_addr;
   logic [CNT_W-1:0]  rd_cnt;
   logic [PROD_W-1:0] acc_sum;
   logic              acc_sat;
   logic              match;
   logic              srch_end;
   logic              out_free;
   logic              div_last;

   // radix clamped into the supported range
   always_comb begin
      if (csr_ff < RDX_W'(RADIX_MIN)) begin
         radix = RDX_W'(RADIX_MIN);
      end else if (csr_ff > RDX_W'(MAX_SYMBOLS)) begin
         radix = RDX_W'(MAX_SYMBOLS);
      end else begin
         radix = csr_ff;
      end
   end

   // restoring division, several quotient bits a cycle; remainder stays below radix
   always_comb begin
      logic [WORK_W-1:0] w;
      logic [RDX_W-1:0]  r;
      w = work_ff;
      r = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         r = {r[RDX_W-2:0], w[WORK_W-1]};
         w = {w[WORK_W-2:0], 1'b0};
         if (r >= radix) begin
            r    = r - radix;
            w[0] = 1'b1;
         end
      end
      div_work_in = w;
      div_rem_in  = r;
   end

   assign div_last = (round_ff == RND_W'(DIV_ROUNDS - 1));
   assign rd_cnt   = cnt_ff - CNT_W'(1);
   assign tbl_addr = cmd.tbl_sel_dig ? dig_rd_ff : srch_ff;
   assign match    = (tbl_rd_ff == sym_ff);
   assign srch_end = ({1'b0, srch_ff} == (radix - RDX_W'(1)));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign acc_sum  = PROD_W'(acc_ff) * PROD_W'(radix) + PROD_W'(srch_ff);
   assign acc_sat  = (acc_sum > PROD_W'(VAL_MAX));

   always_comb begin
      sts          = '0;
      sts.req_zero = (req.value == '0);
      sts.div_last = div_last;
      sts.quo_zero = (div_work_in == '0);
      sts.dig_full = (cnt_ff == CNT_W'(MAX_DIGITS - 1));
      sts.cnt_one  = (cnt_ff == CNT_W'(1));
      sts.match    = match;
      sts.srch_end = srch_end;
      sts.eos      = eos_ff;
      sts.out_free = out_free;
   end

   // symbol table and digit buffer
   always_ff @(posedge clock) begin
      if (cmd.load_tbl) begin
         table_mem[req.slot[TBL_AW-1:0]] <= req.symbol;
      end
      if (cmd.tbl_rd) begin
         tbl_rd_ff <= table_mem[tbl_addr];
      end
      if (cmd.div_step && div_last) begin
         dig_mem[cnt_ff[DIG_AW-1:0]] <= div_rem_in[TBL_AW-1:0];
      end
      if (cmd.dig_rd) begin
         dig_rd_ff <= dig_mem[rd_cnt[DIG_AW-1:0]];
      end
   end

   // transaction payload held for the work
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         work_ff <= WORK_W'(req.value);
         sym_ff  <= req.symbol;
         eos_ff  <= req.end_of_string;
      end else if (cmd.div_step) begin
         work_ff <= div_work_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff      <= RDX_W'(CSR_RESET);
         rem_ff      <= '0;
         round_ff    <= '0;
         cnt_ff      <= '0;
         srch_ff     <= '0;
         acc_ff      <= '0;
         invalid_ff  <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            csr_ff <= csr_write_data;
         end
         if (cmd.accept) begin
            rem_ff   <= '0;
            round_ff <= '0;
            cnt_ff   <= '0;
            srch_ff  <= '0;
         end else if (cmd.div_step) begin
            if (div_last) begin
               rem_ff   <= '0;
               round_ff <= '0;
               cnt_ff   <= cnt_ff + CNT_W'(1);
            end else begin
               rem_ff   <= div_rem_in;
               round_ff <= round_ff + RND_W'(1);
            end
         end else if (cmd.emit_sym) begin
            cnt_ff <= rd_cnt;
         end
         if (cmd.srch_cmp) begin
            srch_ff <= srch_ff + TBL_AW'(1);
            if (match) begin
               if (acc_sat) begin
                  acc_ff      <= VAL_MAX;
                  overflow_ff <= 1'b1;
               end else begin
                  acc_ff <= acc_sum[VAL_W-1:0];
               end
            end else if (srch_end) begin
               invalid_ff <= 1'b1;
            end
         end else if (cmd.emit_dec) begin
            acc_ff      <= '0;
            invalid_ff  <= 1'b0;
            overflow_ff <= 1'b0;
         end
      end
   end

   // output register
   always_comb begin
      rsp_in      = '0;
      rsp_in.last = 1'b1;
      if (cmd.emit_sym) begin
         rsp_in.kind         = KIND_SYMBOL;
         rsp_in.digit_symbol = tbl_rd_ff;
         rsp_in.last         = (cnt_ff == CNT_W'(1));
      end else if (cmd.emit_zero) begin
         rsp_in.kind = KIND_EMPTY;
      end else if (invalid_ff) begin
         rsp_in.kind = KIND_INVALID;
      end else if (overflow_ff) begin
         rsp_in.kind    = KIND_OVERFLOW;
         rsp_in.decoded = VAL_MAX;
      end else begin
         rsp_in.kind    = KIND_VALUE;
         rsp_in.decoded = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sym || cmd.emit_zero || cmd.emit_dec) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_sym || cmd.emit_zero || cmd.emit_dec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/alphabet_radix_codec.sv -----
// top level of the alphabet radix codec
//
//   channel   direction  handshake        payload
//   req_if    in         valid / ready    op, slot, symbol, value, end_of_string
//   rsp_if    out        valid / ready    kind, digit_symbol, decoded, last
//   csr       in         write enable     symbol_count (5 bits)
//
// one request transaction at a time; every op is accepted in the idle state, load and unused op do nothing more
// encode: each digit is divided out in the divider (8 quotient bits a cycle), then each
//   symbol is sent through digit buffer read, table read, output register; a zero value sends one empty result
// decode: each table slot searched is read and then compared, then a finishing state ends the character
// a held output stalls the sequence at the next result; nothing else waits
// synchronous reset, no clearing pass
`default_nettype none

module alphabet_radix_codec (
   input  wire logic                      clock,
   input  wire logic                      reset,
   arc_req_if.sink                        req_if,
   arc_rsp_if.source                      rsp_if,
   input  wire logic                      csr_write_enable,
   input  wire logic [arc_pkg::RDX_W-1:0] csr_write_data
);
   import arc_pkg::*;

   arc_req_type req;
   arc_rsp_type rsp;
   arc_cmd_type cmd;
   arc_sts_type sts;
   logic        rsp_valid;

   assign req = {req_if.op, req_if.slot, req_if.symbol, req_if.value, req_if.end_of_string};

   arc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_op    (req_if.op),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   arc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp              (rsp),
      .rsp_ready        (rsp_if.ready)
   );

   assign rsp_if.valid        = rsp_valid;
   assign rsp_if.kind         = rsp.kind;
   assign rsp_if.digit_symbol = rsp.digit_symbol;
   assign rsp_if.decoded      = rsp.decoded;
   assign rsp_if.last         = rsp.last;

endmodule

`default_nettype wire
